// ===== sv/bba_pkg.sv =====
// ----------------------------------------------------------------------------
// bba_pkg
// Shared codes for the buddy block allocator: result status, slot tag kinds and header sizes.
// ----------------------------------------------------------------------------
package bba_pkg;

	typedef logic [1:0] status_t;

	localparam status_t ST_OK      = 2'd0;
	localparam status_t ST_OOM     = 2'd1;
	localparam status_t ST_BADFREE = 2'd2;

	// slot tag kind, stored above the order field
	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_FREE = 2'd1;
	localparam logic [1:0] KIND_USED = 2'd2;

	localparam logic [15:0] HDR_BYTES   = 16'd8;
	localparam logic [16:0] EXTRA_BYTES = 17'd9;

endpackage

// ===== sv/bba_ram.sv =====
// ----------------------------------------------------------------------------
// bba_ram
// Simple dual-port slot memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module bba_ram #(
	parameter int AW = 11,
	parameter int DW = 12
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [2**AW];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== sv/buddy_block_allocator.sv =====
// ----------------------------------------------------------------------------
// buddy_block_allocator
// Buddy allocator over a 2^MAX_ORDER byte pool with per-order free lists.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over the three slot memories of
// 2^(MAX_ORDER-MIN_ORDER) slots (2048 at the defaults) and accepts no request
// meanwhile. One request is handled at a time by a small sequencer around a
// shared order register and three slot memories with registered reads.
// An allocate sizes the request to an order, searches upward for a non-empty
// list and splits the popped block down level by level; a free checks the
// slot tag, merges with free buddies as far as they go and ends with the
// final list insert. The result sits in an output register until taken.
module buddy_block_allocator #(
	parameter int MIN_ORDER = 5,
	parameter int MAX_ORDER = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              op,
	input  logic [15:0]       request_size,
	input  logic [15:0]       free_offset,
	output logic              out_valid,
	input  logic              out_ready,
	output bba_pkg::status_t  status,
	output logic [15:0]       granted_offset
);

	import bba_pkg::*;

	localparam int SLW = MAX_ORDER - MIN_ORDER;
	localparam int NO  = SLW + 1;
	localparam int NUM_SLOTS = 2 ** SLW;
	localparam int OW  = $clog2(NO);
	localparam int PW  = SLW + 1;
	localparam int TW  = 2 + OW;
	localparam logic [PW-1:0] NIL = {1'b1, {SLW{1'b0}}};
	localparam logic [OW-1:0] TOP = OW'(NO - 1);

	localparam logic [3:0] S_CLR  = 4'd0;
	localparam logic [3:0] S_IDLE = 4'd1;
	localparam logic [3:0] S_ORD  = 4'd2;
	localparam logic [3:0] S_SRCH = 4'd3;
	localparam logic [3:0] S_SUL  = 4'd4;
	localparam logic [3:0] S_PA   = 4'd5;
	localparam logic [3:0] S_PB   = 4'd6;
	localparam logic [3:0] S_FTAG = 4'd7;
	localparam logic [3:0] S_MCHK = 4'd8;
	localparam logic [3:0] S_MTAG = 4'd9;
	localparam logic [3:0] S_DONE = 4'd10;

	logic [3:0]     state_q;
	logic           op_q;
	logic [16:0]    need_q;
	logic [OW-1:0]  idx_q;
	logic [OW-1:0]  k_q;
	logic [SLW-1:0] s_q;
	logic [SLW-1:0] b_q;
	logic [SLW-1:0] ps_q;
	logic [PW-1:0]  h_q;
	logic           second_q;
	logic [SLW-1:0] clr_q;
	status_t        res_st_q;
	logic [15:0]    res_off_q;
	logic [PW-1:0]  head_q [NO];

	// memory ports
	logic           nxt_we, prv_we, tag_we;
	logic [SLW-1:0] nxt_wa, prv_wa, tag_wa;
	logic [PW-1:0]  nxt_wd, prv_wd;
	logic [TW-1:0]  tag_wd;
	logic [SLW-1:0] nxt_ra, prv_ra, tag_ra;
	logic [PW-1:0]  nxt_rd, prv_rd;
	logic [TW-1:0]  tag_rd;

	bba_ram #(.AW(SLW), .DW(PW)) u_nxt (
		.clk(clk), .we(nxt_we), .waddr(nxt_wa), .wdata(nxt_wd),
		.raddr(nxt_ra), .rdata(nxt_rd)
	);
	bba_ram #(.AW(SLW), .DW(PW)) u_prv (
		.clk(clk), .we(prv_we), .waddr(prv_wa), .wdata(prv_wd),
		.raddr(prv_ra), .rdata(prv_rd)
	);
	bba_ram #(.AW(SLW), .DW(TW)) u_tag (
		.clk(clk), .we(tag_we), .waddr(tag_wa), .wdata(tag_wd),
		.raddr(tag_ra), .rdata(tag_rd)
	);

	// free offset checks
	logic [15:0] off_w;
	logic [31:0] fslot_w;
	logic        fbad_w;
	always_comb begin
		off_w   = free_offset - HDR_BYTES;
		fslot_w = 32'(off_w) >> MIN_ORDER;
		fbad_w  = (free_offset < HDR_BYTES) ||
			((32'(off_w) & ((32'd1 << MIN_ORDER) - 32'd1)) != 32'd0) ||
			(fslot_w >= 32'(NUM_SLOTS));
	end

	// shared order/slot arithmetic
	logic           fits_w;
	logic [PW-1:0]  hk_w;
	logic [SLW-1:0] buddy_w;
	logic [SLW-1:0] half_w;
	logic [15:0]    grant_w;
	logic [SLW-1:0] lo_w;
	always_comb begin
		fits_w  = (33'd1 << (32'(idx_q) + MIN_ORDER)) >= 33'(need_q);
		hk_w    = head_q[k_q];
		buddy_w = s_q ^ (SLW'(1) << k_q);
		half_w  = s_q + (SLW'(1) << (k_q - OW'(1)));
		grant_w = 16'((32'(s_q) << MIN_ORDER) + 32'(HDR_BYTES));
		lo_w    = (s_q < b_q) ? s_q : b_q;
	end

	assign in_ready = (state_q == S_IDLE);

	// memory port control
	always_comb begin
		nxt_we = 1'b0; nxt_wa = '0; nxt_wd = NIL;
		prv_we = 1'b0; prv_wa = '0; prv_wd = NIL;
		tag_we = 1'b0; tag_wa = '0; tag_wd = '0;
		nxt_ra = hk_w[SLW-1:0];
		prv_ra = buddy_w;
		tag_ra = buddy_w;
		case (state_q)
			S_CLR: begin
				nxt_we = 1'b1; nxt_wa = clr_q;
				prv_we = 1'b1; prv_wa = clr_q;
				tag_we = 1'b1; tag_wa = clr_q;
				tag_wd = (clr_q == '0) ? {KIND_FREE, TOP} : {KIND_NONE, OW'(0)};
			end
			S_IDLE: begin
				tag_ra = fslot_w[SLW-1:0];
			end
			S_MCHK: begin
				nxt_ra = buddy_w;
			end
			S_SUL: begin
				if (!nxt_rd[PW-1]) begin
					prv_we = 1'b1; prv_wa = nxt_rd[SLW-1:0]; prv_wd = NIL;
				end
				if (k_q == idx_q) begin
					tag_we = 1'b1; tag_wa = s_q; tag_wd = {KIND_USED, idx_q};
				end
			end
			S_PA: begin
				nxt_we = 1'b1; nxt_wa = ps_q; nxt_wd = hk_w;
				prv_we = 1'b1; prv_wa = ps_q; prv_wd = NIL;
				tag_we = 1'b1; tag_wa = ps_q; tag_wd = {KIND_FREE, k_q};
			end
			S_PB: begin
				if (!h_q[PW-1]) begin
					prv_we = 1'b1; prv_wa = h_q[SLW-1:0]; prv_wd = {1'b0, ps_q};
				end
			end
			S_FTAG: begin
				if (tag_rd[TW-1 -: 2] == KIND_USED) begin
					tag_we = 1'b1; tag_wa = s_q; tag_wd = {KIND_NONE, OW'(0)};
				end
			end
			S_MTAG: begin
				if (tag_rd == {KIND_FREE, k_q}) begin
					if (!prv_rd[PW-1]) begin
						nxt_we = 1'b1; nxt_wa = prv_rd[SLW-1:0]; nxt_wd = nxt_rd;
					end
					if (!nxt_rd[PW-1]) begin
						prv_we = 1'b1; prv_wa = nxt_rd[SLW-1:0]; prv_wd = prv_rd;
					end
					tag_we = 1'b1; tag_wa = b_q; tag_wd = {KIND_NONE, OW'(0)};
				end
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLR;
			clr_q     <= '0;
			out_valid <= 1'b0;
			second_q  <= 1'b0;
			for (int i = 0; i < NO; i++) begin
				head_q[i] <= (i == NO - 1) ? {1'b0, SLW'(0)} : NIL;
			end
		end else begin
			if (out_valid && out_ready && state_q != S_DONE) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + SLW'(1);
					if (clr_q == {SLW{1'b1}}) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						op_q  <= op;
						idx_q <= '0;
						if (!op) begin
							need_q  <= 17'(request_size) + EXTRA_BYTES;
							state_q <= S_ORD;
						end else if (fbad_w) begin
							res_st_q  <= ST_BADFREE;
							res_off_q <= '0;
							state_q   <= S_DONE;
						end else begin
							s_q     <= fslot_w[SLW-1:0];
							state_q <= S_FTAG;
						end
					end
				end
				// size to order
				S_ORD: begin
					if (fits_w) begin
						k_q     <= idx_q;
						state_q <= S_SRCH;
					end else if (idx_q == TOP) begin
						res_st_q  <= ST_OOM;
						res_off_q <= '0;
						state_q   <= S_DONE;
					end else begin
						idx_q <= idx_q + OW'(1);
					end
				end
				// find smallest non-empty list
				S_SRCH: begin
					if (!hk_w[PW-1]) begin
						s_q     <= hk_w[SLW-1:0];
						state_q <= S_SUL;
					end else if (k_q == TOP) begin
						res_st_q  <= ST_OOM;
						res_off_q <= '0;
						state_q   <= S_DONE;
					end else begin
						k_q <= k_q + OW'(1);
					end
				end
				// pop list head, then grant or split
				S_SUL: begin
					head_q[k_q] <= nxt_rd;
					if (k_q == idx_q) begin
						res_st_q  <= ST_OK;
						res_off_q <= grant_w;
						state_q   <= S_DONE;
					end else begin
						k_q      <= k_q - OW'(1);
						ps_q     <= half_w;
						second_q <= 1'b0;
						state_q  <= S_PA;
					end
				end
				// list push, first half
				S_PA: begin
					h_q         <= hk_w;
					head_q[k_q] <= {1'b0, ps_q};
					state_q     <= S_PB;
				end
				// list push, back link
				S_PB: begin
					if (op_q) begin
						res_st_q  <= ST_OK;
						res_off_q <= '0;
						state_q   <= S_DONE;
					end else if (!second_q) begin
						second_q <= 1'b1;
						ps_q     <= s_q;
						state_q  <= S_PA;
					end else begin
						state_q <= S_SRCH;
					end
				end
				S_FTAG: begin
					if (tag_rd[TW-1 -: 2] != KIND_USED) begin
						res_st_q  <= ST_BADFREE;
						res_off_q <= '0;
						state_q   <= S_DONE;
					end else begin
						k_q     <= tag_rd[OW-1:0];
						state_q <= S_MCHK;
					end
				end
				// merge step: look up buddy
				S_MCHK: begin
					if (k_q == TOP) begin
						ps_q    <= s_q;
						state_q <= S_PA;
					end else begin
						b_q     <= buddy_w;
						state_q <= S_MTAG;
					end
				end
				S_MTAG: begin
					if (tag_rd == {KIND_FREE, k_q}) begin
						if (prv_rd[PW-1]) begin
							head_q[k_q] <= nxt_rd;
						end
						s_q     <= lo_w;
						k_q     <= k_q + OW'(1);
						state_q <= S_MCHK;
					end else begin
						ps_q    <= s_q;
						state_q <= S_PA;
					end
				end
				S_DONE: begin
					if (!out_valid || out_ready) begin
						out_valid      <= 1'b1;
						status         <= res_st_q;
						granted_offset <= res_off_q;
						state_q        <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
